// ===== design/ffcp_pkg.sv =====
// Shared constants for the fixed frame command parser.
package ffcp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned TALLY_W = 4;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [TALLY_W-1:0] tally_t;

    localparam byte_t HEADER_BYTE = 8'hFF;
    localparam byte_t TAIL_BYTE   = 8'hF0;

    // Frame byte positions.
    localparam pos_t POS_IDLE       = 4'd0;
    localparam pos_t POS_FIRST_DATA = 4'd2;
    localparam pos_t POS_MODE       = 4'd5;
    localparam pos_t POS_YAW_HI     = 4'd6;
    localparam pos_t POS_YAW_LO     = 4'd7;
    localparam pos_t POS_SPEED_HI   = 4'd8;
    localparam pos_t POS_SPEED_LO   = 4'd9;
    localparam pos_t POS_PITCH_HI   = 4'd10;
    localparam pos_t POS_PITCH_LO   = 4'd11;
    localparam pos_t POS_CHECK      = 4'd12;
    localparam pos_t POS_TAIL_1     = 4'd13;
    localparam pos_t POS_LAST       = 4'd14;

    // Largest tally: ten data bytes, all odd.
    localparam tally_t TALLY_MAX = 4'd10;

endpackage

// ===== design/fixed_frame_command_parser_core.sv =====
// Fixed 15-byte command frame parser: header hunt, field capture, check and tail test.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------------
//  in      | in  | in_valid/in_ready  | rx_byte[7:0]
//  out     | out | out_valid/out_ready| mode_byte[7:0], yaw_value, speed_value,
//          |     |                    | pitch_value (signed [15:0] each)
//
//  - One word per cycle unless the output stalls: a word is captured in the input
//    register, then the parser state advances and any result lands in the output register.
//  - A finished frame shows on out_valid once the parser has processed its last word.
//  - rst_n (async, low) returns the parser to header hunt with both registers empty.
//  - A stalled output blocks parser progress only when the input register is full;
//    in_ready then drops until the pending result is taken.
//  - Bad frames (check or tail mismatch) are dropped with no result word.
module fixed_frame_command_parser_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         mode_byte,
    output logic signed [15:0] yaw_value,
    output logic signed [15:0] speed_value,
    output logic signed [15:0] pitch_value
);

    // Input register.
    logic              in_valid_reg;
    ffcp_pkg::byte_t   in_byte_reg;

    // Parser control state.
    logic              in_frame_reg,      in_frame_next;
    ffcp_pkg::pos_t    byte_position_reg, byte_position_next;
    logic              ff_seen_reg,       ff_seen_next;
    ffcp_pkg::tally_t  parity_tally_reg,  parity_tally_next;
    logic              tail_first_ok_reg, tail_first_ok_next;

    // Captured frame fields (written before use, no reset).
    ffcp_pkg::byte_t   mode_hold_reg;
    logic [15:0]       yaw_hold_reg;
    logic [15:0]       speed_hold_reg;
    logic [15:0]       pitch_hold_reg;
    ffcp_pkg::byte_t   check_hold_reg;

    // Output register.
    logic              out_valid_reg;
    ffcp_pkg::byte_t   mode_out_reg;
    logic signed [15:0] yaw_out_reg;
    logic signed [15:0] speed_out_reg;
    logic signed [15:0] pitch_out_reg;

    logic advance;      // parser consumes the word in the input register
    logic frame_end;
    logic frame_ok;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Positions outside 2..14 in a frame cannot occur; treat them as the end.
    assign frame_end = (byte_position_reg >= ffcp_pkg::POS_LAST)
                    || (byte_position_reg <  ffcp_pkg::POS_FIRST_DATA);
    assign frame_ok  = in_frame_reg
                    && (byte_position_reg == ffcp_pkg::POS_LAST)
                    && (check_hold_reg == {4'd0, parity_tally_reg})
                    && tail_first_ok_reg
                    && (in_byte_reg == ffcp_pkg::TAIL_BYTE);

    always_comb
    begin
        in_frame_next      = in_frame_reg;
        byte_position_next = byte_position_reg;
        ff_seen_next       = ff_seen_reg;
        parity_tally_next  = parity_tally_reg;
        tail_first_ok_next = tail_first_ok_reg;
        if (!in_frame_reg)
        begin
            // Header hunt: two 0xFF in a row open a frame.
            if (in_byte_reg == ffcp_pkg::HEADER_BYTE)
            begin
                if (ff_seen_reg)
                begin
                    ff_seen_next       = 1'b0;
                    in_frame_next      = 1'b1;
                    byte_position_next = ffcp_pkg::POS_FIRST_DATA;
                    parity_tally_next  = '0;
                end
                else
                begin
                    ff_seen_next = 1'b1;
                end
            end
            else
            begin
                ff_seen_next = 1'b0;
            end
        end
        else
        begin
            if (byte_position_reg >= ffcp_pkg::POS_FIRST_DATA
                && byte_position_reg <= ffcp_pkg::POS_PITCH_LO)
            begin
                parity_tally_next = parity_tally_reg + {3'd0, in_byte_reg[0]};
            end
            if (byte_position_reg == ffcp_pkg::POS_TAIL_1)
            begin
                tail_first_ok_next = (in_byte_reg == ffcp_pkg::TAIL_BYTE);
            end
            if (frame_end)
            begin
                in_frame_next      = 1'b0;
                byte_position_next = ffcp_pkg::POS_IDLE;
            end
            else
            begin
                byte_position_next = byte_position_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            in_frame_reg      <= 1'b0;
            byte_position_reg <= ffcp_pkg::POS_IDLE;
            ff_seen_reg       <= 1'b0;
            parity_tally_reg  <= '0;
            tail_first_ok_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                in_frame_reg      <= in_frame_next;
                byte_position_reg <= byte_position_next;
                ff_seen_reg       <= ff_seen_next;
                parity_tally_reg  <= parity_tally_next;
                tail_first_ok_reg <= tail_first_ok_next;
            end
            if (advance && frame_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && in_frame_reg)
        begin
            unique case (byte_position_reg)
                ffcp_pkg::POS_MODE:     mode_hold_reg        <= in_byte_reg;
                ffcp_pkg::POS_YAW_HI:   yaw_hold_reg[15:8]   <= in_byte_reg;
                ffcp_pkg::POS_YAW_LO:   yaw_hold_reg[7:0]    <= in_byte_reg;
                ffcp_pkg::POS_SPEED_HI: speed_hold_reg[15:8] <= in_byte_reg;
                ffcp_pkg::POS_SPEED_LO: speed_hold_reg[7:0]  <= in_byte_reg;
                ffcp_pkg::POS_PITCH_HI: pitch_hold_reg[15:8] <= in_byte_reg;
                ffcp_pkg::POS_PITCH_LO: pitch_hold_reg[7:0]  <= in_byte_reg;
                ffcp_pkg::POS_CHECK:    check_hold_reg       <= in_byte_reg;
                default: ;
            endcase
        end
        if (advance && frame_ok)
        begin
            mode_out_reg  <= mode_hold_reg;
            yaw_out_reg   <= yaw_hold_reg;
            speed_out_reg <= speed_hold_reg;
            pitch_out_reg <= pitch_hold_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mode_byte   = mode_out_reg;
    assign yaw_value   = yaw_out_reg;
    assign speed_value = speed_out_reg;
    assign pitch_value = pitch_out_reg;

    // Frame position stays inside the frame range (positions 2 to 14) while a frame is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (byte_position_reg >= ffcp_pkg::POS_FIRST_DATA
                          && byte_position_reg <= ffcp_pkg::POS_LAST))
        else $error("frame position out of range");

    // Hunting always parks the position at idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (byte_position_reg == ffcp_pkg::POS_IDLE))
        else $error("position not idle while hunting");

    // Header flag is never left set inside a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> !ff_seen_reg)
        else $error("header flag set inside frame");

    // Tally cannot exceed the count of data bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        parity_tally_reg <= ffcp_pkg::TALLY_MAX)
        else $error("parity tally overflow");

    // A new result only follows a processed last frame word.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && in_frame_reg
                                       && byte_position_reg == ffcp_pkg::POS_LAST))
        else $error("result without frame end");

endmodule
